[sv/chained_hash_table_engine_macros.svh]
`ifndef CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cht check failed: lbl");

// next-cycle implication, checked out of reset
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cht check failed: lbl");

`endif

[sv/cht_pkg.sv]
package cht_pkg;

    localparam int DEF_MAX_BUCKETS = 1024;
    localparam int DEF_POOL_NODES  = 1024;
    localparam int DEF_KEY_BYTES   = 8;

    localparam int CFG_W    = 11;
    localparam int COUNT_W  = 11;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int LEN_W    = 4;
    localparam int HASH_W   = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] BC_RESET = 11'd1021;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } cht_cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_FULL     = 3'd4
    } cht_status_t;

    typedef struct packed {
        cht_cmd_t           cmd;
        logic [KEY_W-1:0]   key;
        logic [LEN_W-1:0]   len;
        logic [VAL_W-1:0]   val;
    } cht_item_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_HASH,
        F_FIN,
        F_DIV,
        F_PUSH
    } cht_front_state_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_HEAD,
        B_CHECK,
        B_NODE,
        B_DECIDE,
        B_FREE,
        B_ALLOC,
        B_LINK
    } cht_back_state_t;

endpackage

[sv/cht_ram.sv]
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/cht_queue.sv]
module cht_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             valid
);
    import cht_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/cht_front.sv]
module cht_front #(
    parameter int MAX_BUCKETS = 1024,
    parameter int KEY_BYTES   = 8,
    parameter int BW          = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      enable,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cht_pkg::cht_item_t        in_item,
    input  logic [cht_pkg::CFG_W-1:0] num_buckets,
    input  logic                      q_full,
    output logic                      q_push,
    output cht_pkg::cht_item_t        q_item,
    output logic [BW-1:0]             q_bucket
);
    import cht_pkg::*;

    cht_front_state_t state_reg, state_next;
    cht_item_t        item_reg, item_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [LEN_W-1:0]  i_reg, i_next;
    logic [CFG_W-1:0]  rem_reg, rem_next;
    logic [CFG_W-1:0]  bc_reg, bc_next;
    logic [4:0]        div_reg, div_next;

    logic [LEN_W-1:0]  len_c;
    logic [KEY_W-1:0]  key_m;
    logic [CFG_W-1:0]  bc_c;
    logic [7:0]        hbyte;
    logic [HASH_W-1:0] r1, r2, r3, f1, f2, f3;
    logic [CFG_W:0]    trial;
    logic              fits;

    assign in_ready = enable && (state_reg == F_IDLE);
    assign q_item   = item_reg;
    assign q_bucket = BW'(rem_reg);

    always_comb
    begin
        len_c = (in_item.len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_item.len;
        for (int k = 0; k < KEY_W / 8; k++)
        begin
            key_m[8*k +: 8] = (LEN_W'(k) < len_c) ? in_item.key[8*k +: 8] : 8'd0;
        end
        if (num_buckets == '0)
        begin
            bc_c = CFG_W'(1);
        end
        else if ((MAX_BUCKETS < (1 << CFG_W)) && (num_buckets > CFG_W'(MAX_BUCKETS)))
        begin
            bc_c = CFG_W'(MAX_BUCKETS);
        end
        else
        begin
            bc_c = num_buckets;
        end
    end

    // one-at-a-time round and final mix
    always_comb
    begin
        hbyte = item_reg.key[{i_reg[2:0], 3'b000} +: 8];
        r1 = h_reg + HASH_W'(hbyte);
        r2 = r1 + (r1 << 10);
        r3 = r2 ^ (r2 >> 6);
        f1 = h_reg + (h_reg << 3);
        f2 = f1 ^ (f1 >> 11);
        f3 = f2 + (f2 << 15);
        trial = {rem_reg, h_reg[HASH_W-1]};
        fits  = (trial >= {1'b0, bc_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = F_HASH;
                end
            end
            F_HASH:
            begin
                if (i_reg == item_reg.len)
                begin
                    state_next = F_FIN;
                end
            end
            F_FIN:
            begin
                state_next = F_DIV;
            end
            F_DIV:
            begin
                if (div_reg == 5'd31)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_next = item_reg;
        h_next    = h_reg;
        i_next    = i_reg;
        rem_next  = rem_reg;
        bc_next   = bc_reg;
        div_next  = div_reg;
        q_push    = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                item_next     = in_item;
                item_next.key = key_m;
                item_next.len = len_c;
                bc_next       = bc_c;
                h_next        = '0;
                i_next        = '0;
            end
            F_HASH:
            begin
                if (i_reg != item_reg.len)
                begin
                    h_next = r3;
                    i_next = i_reg + 1'b1;
                end
            end
            F_FIN:
            begin
                h_next   = f3;
                rem_next = '0;
                div_next = '0;
            end
            F_DIV:
            begin
                // restoring remainder, one hash bit per cycle
                rem_next = fits ? CFG_W'(trial - {1'b0, bc_reg}) : trial[CFG_W-1:0];
                h_next   = h_reg << 1;
                div_next = div_reg + 1'b1;
            end
            F_PUSH:
            begin
                q_push = !q_full;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        h_reg    <= h_next;
        i_reg    <= i_next;
        rem_reg  <= rem_next;
        bc_reg   <= bc_next;
        div_reg  <= div_next;
    end

endmodule

[sv/cht_back.sv]
`include "chained_hash_table_engine_macros.svh"

module cht_back #(
    parameter int MAX_BUCKETS = 1024,
    parameter int POOL_NODES  = 1024,
    parameter int KEY_BYTES   = 8,
    parameter int BW          = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    output logic                        ready_init,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  cht_pkg::cht_item_t          q_item,
    input  logic [BW-1:0]               q_bucket,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cht_pkg::cht_status_t        out_status,
    output logic [cht_pkg::VAL_W-1:0]   out_value,
    output logic [cht_pkg::COUNT_W-1:0] out_count
);
    import cht_pkg::*;

    localparam int PW = $clog2(POOL_NODES);
    localparam int NW = PW + 1;
    localparam int KW = KEY_BYTES * 8;
    localparam int KRAM_W = KW + LEN_W;
    localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

    cht_back_state_t state_reg, state_next;
    cht_item_t       item_reg, item_next;
    logic [BW-1:0]   bucket_reg, bucket_next;
    logic [BW-1:0]   clr_reg, clr_next;
    logic [NW-1:0]   cur_reg, cur_next;
    logic [NW-1:0]   prev_reg, prev_next;
    logic [NW-1:0]   steps_reg, steps_next;
    logic            hit_reg, hit_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [NW-1:0]   free_top_reg, free_top_next;
    logic [NW-1:0]   fresh_reg, fresh_next;
    logic [NW-1:0]   held_reg, held_next;
    logic            out_valid_reg;
    cht_status_t     out_status_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic            res_load;
    cht_status_t     res_status;
    logic [VAL_W-1:0] res_value;

    logic            head_we, head_re;
    logic [BW-1:0]   head_waddr, head_raddr;
    logic [NW-1:0]   head_wdata, head_rdata;
    logic            key_we, node_re, val_we, link_we, free_we, free_re;
    logic [PW-1:0]   key_waddr, val_waddr, link_waddr, free_waddr, free_raddr, node_raddr;
    logic [KRAM_W-1:0] key_wdata, key_rdata;
    logic [VAL_W-1:0]  val_wdata, val_rdata;
    logic [NW-1:0]     link_wdata, link_rdata;
    logic [PW-1:0]     free_wdata, free_rdata;
    logic              match;

    cht_ram #(.WIDTH(NW), .DEPTH(MAX_BUCKETS)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
    );
    cht_ram #(.WIDTH(KRAM_W), .DEPTH(POOL_NODES)) u_key (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(key_rdata)
    );
    cht_ram #(.WIDTH(VAL_W), .DEPTH(POOL_NODES)) u_val (
        .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(val_rdata)
    );
    cht_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(link_rdata)
    );
    cht_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_free (
        .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
        .re(free_re), .raddr(free_raddr), .rdata(free_rdata)
    );

    assign ready_init = (state_reg != B_CLEAR);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_count  = out_count_reg;
    assign match = (key_rdata[KRAM_W-1 -: LEN_W] == item_reg.len) &&
                   (key_rdata[KW-1:0] == item_reg.key[KW-1:0]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_reg == BW'(MAX_BUCKETS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    state_next = B_HEAD;
                end
            end
            B_HEAD:
            begin
                state_next = (item_reg.cmd == CMD_NOP) ? B_IDLE : B_CHECK;
            end
            B_CHECK:
            begin
                if (cur_reg == NIL || steps_reg == NW'(POOL_NODES))
                begin
                    state_next = B_DECIDE;
                end
                else
                begin
                    state_next = B_NODE;
                end
            end
            B_NODE:
            begin
                state_next = match ? B_DECIDE : B_CHECK;
            end
            B_DECIDE:
            begin
                if (item_reg.cmd == CMD_PUT && !hit_reg)
                begin
                    if (free_top_reg != '0)
                    begin
                        state_next = B_FREE;
                    end
                    else if (fresh_reg < NW'(POOL_NODES))
                    begin
                        state_next = B_ALLOC;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            B_FREE:
            begin
                state_next = B_ALLOC;
            end
            B_ALLOC:
            begin
                state_next = B_LINK;
            end
            B_LINK:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_next     = item_reg;
        bucket_next   = bucket_reg;
        clr_next      = clr_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        steps_next    = steps_reg;
        hit_next      = hit_reg;
        n_next        = n_reg;
        free_top_next = free_top_reg;
        fresh_next    = fresh_reg;
        held_next     = held_reg;
        q_pop      = 1'b0;
        res_load   = 1'b0;
        res_status = ST_MISSING;
        res_value  = '0;
        head_we    = 1'b0;
        head_waddr = bucket_reg;
        head_wdata = NIL;
        head_re    = 1'b0;
        head_raddr = q_bucket;
        key_we     = 1'b0;
        key_waddr  = n_reg[PW-1:0];
        key_wdata  = {item_reg.len, item_reg.key[KW-1:0]};
        val_we     = 1'b0;
        val_waddr  = n_reg[PW-1:0];
        val_wdata  = item_reg.val;
        link_we    = 1'b0;
        link_waddr = n_reg[PW-1:0];
        link_wdata = NIL;
        node_re    = 1'b0;
        node_raddr = cur_reg[PW-1:0];
        free_we    = 1'b0;
        free_waddr = free_top_reg[PW-1:0];
        free_wdata = cur_reg[PW-1:0];
        free_re    = 1'b0;
        free_raddr = PW'(free_top_reg - 1'b1);
        case (state_reg)
            B_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
            end
            B_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    q_pop       = 1'b1;
                    head_re     = 1'b1;
                    item_next   = q_item;
                    bucket_next = q_bucket;
                end
            end
            B_HEAD:
            begin
                cur_next   = head_rdata;
                prev_next  = NIL;
                steps_next = '0;
                hit_next   = 1'b0;
                if (item_reg.cmd == CMD_NOP)
                begin
                    res_load = 1'b1;
                end
            end
            B_CHECK:
            begin
                node_re = 1'b1;
            end
            B_NODE:
            begin
                if (match)
                begin
                    hit_next = 1'b1;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    steps_next = steps_reg + 1'b1;
                end
            end
            B_DECIDE:
            begin
                case (item_reg.cmd)
                    CMD_PUT:
                    begin
                        if (hit_reg)
                        begin
                            val_we     = 1'b1;
                            val_waddr  = cur_reg[PW-1:0];
                            res_load   = 1'b1;
                            res_status = ST_REPLACED;
                        end
                        else if (free_top_reg != '0)
                        begin
                            free_re       = 1'b1;
                            free_top_next = free_top_reg - 1'b1;
                        end
                        else if (fresh_reg < NW'(POOL_NODES))
                        begin
                            n_next     = fresh_reg;
                            fresh_next = fresh_reg + 1'b1;
                        end
                        else
                        begin
                            res_load   = 1'b1;
                            res_status = ST_FULL;
                        end
                    end
                    CMD_GET:
                    begin
                        res_load = 1'b1;
                        if (hit_reg)
                        begin
                            res_status = ST_FOUND;
                            res_value  = val_rdata;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        res_load = 1'b1;
                        if (hit_reg)
                        begin
                            res_status = ST_FOUND;
                            res_value  = val_rdata;
                            // splice out the node: link data still holds its successor
                            if (prev_reg != NIL)
                            begin
                                link_we    = 1'b1;
                                link_waddr = prev_reg[PW-1:0];
                                link_wdata = link_rdata;
                            end
                            else
                            begin
                                head_we    = 1'b1;
                                head_wdata = link_rdata;
                            end
                            if (free_top_reg < NW'(POOL_NODES))
                            begin
                                free_we       = 1'b1;
                                free_top_next = free_top_reg + 1'b1;
                            end
                            if (held_reg != '0)
                            begin
                                held_next = held_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        res_load = 1'b1;
                    end
                endcase
            end
            B_FREE:
            begin
                n_next = {1'b0, free_rdata};
            end
            B_ALLOC:
            begin
                key_we  = 1'b1;
                val_we  = 1'b1;
                link_we = 1'b1;
            end
            B_LINK:
            begin
                if (prev_reg != NIL)
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg[PW-1:0];
                    link_wdata = n_reg;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = n_reg;
                end
                held_next  = held_reg + 1'b1;
                res_load   = 1'b1;
                res_status = ST_INSERTED;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            free_top_reg  <= '0;
            fresh_reg     <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            free_top_reg <= free_top_next;
            fresh_reg    <= fresh_next;
            held_reg     <= held_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        bucket_reg <= bucket_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        steps_reg  <= steps_next;
        hit_reg    <= hit_next;
        n_reg      <= n_next;
        if (res_load)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
            out_count_reg  <= COUNT_W'(held_next);
        end
    end

    // pool counters settle only between items: an insert moves them in separate states
    `CHT_ASSERT_NOW(a_count_bound, 1'b1, held_reg <= NW'(POOL_NODES))
    `CHT_ASSERT_NOW(a_pool_balance, state_reg == B_IDLE, held_reg == NW'(fresh_reg - free_top_reg))
    `CHT_ASSERT_NOW(a_no_overwrite, res_load, !out_valid_reg)
    `CHT_ASSERT_NOW(a_no_pop_in_clear, state_reg == B_CLEAR, !q_pop)
    `CHT_ASSERT_NEXT(a_pop_reads_head, q_pop, state_reg == B_HEAD)

endmodule

[sv/chained_hash_table_engine.sv]
// Key-value table with chained buckets. Each item carries a command (put, get, remove, no-op)
// in s_axis_tuser and a key, its length and a value in s_axis_tdata; each item gives exactly
// one result with a status in m_axis_tuser and the value and entry count in m_axis_tdata. The
// front stage hashes the key one byte per cycle and reduces it by the bucket count with a
// bit-serial remainder, and takes a new item only after it has pushed the last one to the
// queue; the back stage reads the bucket head, walks the chain node by node until the key is
// found or the chain ends, and for an insert links in a freed node or else a never-used one;
// it waits while a result is held on m_axis_tready. The two overlap through a two-entry queue,
// so the sustained rate is set by the front stage for short chains and by the chain walk for
// long ones. After reset a pass over all MAX_BUCKETS bucket heads empties them and no item is
// taken until it ends; the bucket count may be written at any time but should only change
// while the block is idle.
module chained_hash_table_engine #(
    parameter int MAX_BUCKETS = cht_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_NODES  = cht_pkg::DEF_POOL_NODES,
    parameter int KEY_BYTES   = cht_pkg::DEF_KEY_BYTES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [10:0]  cfg_wdata,       // number of buckets in use
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,    // key_bytes[63:0], key_len[67:64], value_in[131:68]
    input  logic [1:0]   s_axis_tuser,    // command[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,    // value_out[63:0], entry_count[74:64]
    output logic [2:0]   m_axis_tuser     // status[2:0]
);
    import cht_pkg::*;

    localparam int BW = $clog2(MAX_BUCKETS);
    localparam int QW = $bits(cht_item_t) + BW;

    logic [CFG_W-1:0] num_buckets_reg;
    logic             init_done;
    cht_item_t        in_item, f_item, b_item;
    logic [BW-1:0]    f_bucket, b_bucket;
    logic             q_push, q_full, q_pop, q_valid;
    logic [QW-1:0]    q_out;
    cht_status_t      status;
    logic [VAL_W-1:0] value_out;
    logic [COUNT_W-1:0] entry_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_buckets_reg <= BC_RESET;
        end
        else if (cfg_we)
        begin
            num_buckets_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        in_item.cmd = cht_cmd_t'(s_axis_tuser);
        in_item.key = s_axis_tdata[63:0];
        in_item.len = s_axis_tdata[67:64];
        in_item.val = s_axis_tdata[131:68];
    end

    cht_front #(
        .MAX_BUCKETS(MAX_BUCKETS), .KEY_BYTES(KEY_BYTES), .BW(BW)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .enable(init_done),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .num_buckets(num_buckets_reg),
        .q_full(q_full), .q_push(q_push), .q_item(f_item), .q_bucket(f_bucket)
    );

    cht_queue #(.WIDTH(QW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_data({f_bucket, f_item}), .full(q_full),
        .pop(q_pop), .pop_data(q_out), .valid(q_valid)
    );

    assign b_item   = q_out[$bits(cht_item_t)-1:0];
    assign b_bucket = q_out[QW-1 -: BW];

    cht_back #(
        .MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES),
        .KEY_BYTES(KEY_BYTES), .BW(BW)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .ready_init(init_done),
        .q_valid(q_valid), .q_pop(q_pop), .q_item(b_item), .q_bucket(b_bucket),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_status(status), .out_value(value_out), .out_count(entry_count)
    );

    assign m_axis_tdata = {5'd0, entry_count, value_out};
    assign m_axis_tuser = status;

endmodule
